// ===== design/timed_beep_segment_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// timed beep segment queue core - assertion macros
// shared property macros for the port-level checker
// ----------------------------------------------------------------------------
`ifndef TIMED_BEEP_SEGMENT_QUEUE_CORE_DEFINES_SVH
`define TIMED_BEEP_SEGMENT_QUEUE_CORE_DEFINES_SVH

// antecedent implies consequent at the same edge
`define TBSQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// antecedent implies consequent at a later edge
`define TBSQ_ASSERT_AFTER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("%m: delayed implication failed");

`endif

// ===== design/tbsq_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsq_pkg
// types, codes and helpers shared by the beep segment queue
// ----------------------------------------------------------------------------
package tbsq_pkg;

   localparam int TBSQ_DEPTH = 16;
   localparam int DUR_W      = 16;
   localparam logic [DUR_W-1:0] DUR_MAX = 16'hFFFF;

   // command codes of a request transaction
   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_SINGLE = 3'd1,
      MODE_SQUARE = 3'd2,
      MODE_APPEND = 3'd3,
      MODE_CLEAR  = 3'd4
   } mode_type;

   // decoded command held in the input register
   typedef struct packed {
      logic             tick;
      logic             append;
      logic             load;
      logic             enable_play;
      logic             alternate;
      logic             level_a;
      logic [DUR_W-1:0] dur_a;
      logic [DUR_W-1:0] dur_b;
   } cmd_type;

   // segment queue control
   typedef struct packed {
      logic             load;
      logic             push;
      logic             pop;
      logic             alternate;
      logic             level_a;
      logic [DUR_W-1:0] dur_a;
      logic [DUR_W-1:0] dur_b;
   } fifo_ctl_type;

   // segment queue status
   typedef struct packed {
      logic             empty;
      logic             head_level;
      logic [DUR_W-1:0] head_dur;
   } fifo_stat_type;

   // saturate a 32-bit tick count to the segment duration range
   function automatic logic [DUR_W-1:0] sat_dur(input logic [31:0] v);
      logic [DUR_W-1:0] r;
      r = (|v[31:DUR_W]) ? DUR_MAX : v[DUR_W-1:0];
      return r;
   endfunction

endpackage

// ===== design/tbsq_input_stage.sv =====
// ----------------------------------------------------------------------------
// tbsq_input_stage
// decodes a request transaction and holds it in the input register
// ----------------------------------------------------------------------------
module tbsq_input_stage
   import tbsq_pkg::*;
#(
   parameter int DEPTH  = TBSQ_DEPTH,
   parameter int FILL_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [2:0]        req_mode,
   input  logic              req_segment_level,
   input  logic [31:0]       req_on_ticks,
   input  logic [31:0]       req_off_ticks,
   input  logic [7:0]        req_repeat_count,
   output logic              valid_ff,
   output cmd_type           cmd_ff,
   output logic [FILL_W-1:0] count_ff
);

   localparam logic [7:0] HALF = 8'(DEPTH / 2);

   logic [DUR_W-1:0]  on_d;
   logic [DUR_W-1:0]  off_d;
   logic              on_nz;
   logic              off_nz;
   logic [7:0]        reps_clamp;
   logic [FILL_W-1:0] reps;
   cmd_type           cmd_in;
   logic [FILL_W-1:0] count_in;
   logic              valid_in;

   // saturate durations and clamp the pair count
   always_comb begin
      on_d       = sat_dur(req_on_ticks);
      off_d      = sat_dur(req_off_ticks);
      on_nz      = (on_d != '0);
      off_nz     = (off_d != '0);
      reps_clamp = (req_repeat_count > HALF) ? HALF : req_repeat_count;
      reps       = reps_clamp[FILL_W-1:0];
   end

   // command decode
   always_comb begin
      cmd_in   = '0;
      count_in = '0;
      case (mode_type'(req_mode))
         MODE_TICK: begin
            cmd_in.tick = 1'b1;
         end
         MODE_SINGLE: begin
            cmd_in.load        = 1'b1;
            cmd_in.enable_play = 1'b1;
            cmd_in.level_a     = 1'b1;
            cmd_in.dur_a       = on_d;
            count_in           = FILL_W'(on_nz);
         end
         MODE_SQUARE: begin
            cmd_in.load        = 1'b1;
            cmd_in.enable_play = 1'b1;
            cmd_in.alternate   = on_nz && off_nz;
            // with a zero on time only the off segments remain
            cmd_in.level_a     = on_nz;
            cmd_in.dur_a       = on_nz ? on_d : off_d;
            cmd_in.dur_b       = off_d;
            if (on_nz && off_nz) begin
               count_in = reps << 1;
            end else if (on_nz || off_nz) begin
               count_in = reps;
            end else begin
               count_in = '0;
            end
         end
         MODE_APPEND: begin
            cmd_in.append  = 1'b1;
            cmd_in.level_a = req_segment_level;
            cmd_in.dur_a   = on_d;
         end
         MODE_CLEAR: begin
            cmd_in.load = 1'b1;
         end
         default: begin
            cmd_in = '0;
         end
      endcase
   end

   assign valid_in = accept;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      count_ff <= count_in;
   end

endmodule

// ===== design/tbsq_fifo.sv =====
// ----------------------------------------------------------------------------
// tbsq_fifo
// shifting segment queue with parallel pattern load
// ----------------------------------------------------------------------------
module tbsq_fifo
   import tbsq_pkg::*;
#(
   parameter int DEPTH  = TBSQ_DEPTH,
   parameter int FILL_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  fifo_ctl_type      ctl,
   input  logic [FILL_W-1:0] load_count,
   output fifo_stat_type     stat
);

   localparam logic [FILL_W-1:0] FULL = FILL_W'(DEPTH);

   logic [DEPTH-1:0]             level_ff;
   logic [DEPTH-1:0]             level_in;
   logic [DEPTH-1:0][DUR_W-1:0]  dur_ff;
   logic [DEPTH-1:0][DUR_W-1:0]  dur_in;
   logic [FILL_W-1:0]            fill_ff;
   logic [FILL_W-1:0]            fill_in;
   logic                         push_ok;

   // an append stores only a nonzero duration into a free slot
   assign push_ok = ctl.push && (ctl.dur_a != '0) && (fill_ff != FULL);

   // per-entry next value
   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      localparam logic [FILL_W-1:0] IDX = FILL_W'(k);
      localparam logic              ODD = (k % 2) == 1;
      always_comb begin
         level_in[k] = level_ff[k];
         dur_in[k]   = dur_ff[k];
         if (ctl.load) begin
            if (ctl.alternate && ODD) begin
               level_in[k] = 1'b0;
               dur_in[k]   = ctl.dur_b;
            end else begin
               level_in[k] = ctl.level_a;
               dur_in[k]   = ctl.dur_a;
            end
         end else if (push_ok && (fill_ff == IDX)) begin
            level_in[k] = ctl.level_a;
            dur_in[k]   = ctl.dur_a;
         end else if (ctl.pop) begin
            if (k == DEPTH - 1) begin
               level_in[k] = 1'b0;
               dur_in[k]   = '0;
            end else begin
               level_in[k] = level_ff[(k + 1) % DEPTH];
               dur_in[k]   = dur_ff[(k + 1) % DEPTH];
            end
         end
      end
   end

   // fill count
   always_comb begin
      fill_in = fill_ff;
      if (ctl.load) begin
         fill_in = load_count;
      end else if (push_ok) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop && (fill_ff != '0)) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      dur_ff   <= dur_in;
   end

   // head of queue
   assign stat.empty      = (fill_ff == '0);
   assign stat.head_level = level_ff[0];
   assign stat.head_dur   = dur_ff[0];

endmodule

// ===== design/timed_beep_segment_queue_core.sv =====
// ----------------------------------------------------------------------------
// timed_beep_segment_queue_core
// beeper pattern sequencer: segment queue, countdown and pin drive
// ----------------------------------------------------------------------------
// usage:
//   a command transaction is taken on start while busy is low; req_mode
//   selects tick, single beep, square pattern, append or clear, and the
//   other req_ ports carry level, durations and pair count.
//   every transaction yields one result: rsp_valid pulses for one cycle with
//   rsp_pin_level, the beeper level after that command.
// pipeline and throughput:
//   the result follows acceptance through the input register, then the update of
//   queue, countdown and pin into the result register; one transaction per
//   cycle, since every command updates the whole queue at once.
// reset:
//   synchronous; empties the queue, zeroes the countdown, turns playback and
//   the pin off and drops transactions in flight. busy is high during reset.
// receiver:
//   results cannot be held off; rsp_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
module timed_beep_segment_queue_core
   import tbsq_pkg::*;
#(
   parameter int DEPTH = TBSQ_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic        req_segment_level,
   input  logic [31:0] req_on_ticks,
   input  logic [31:0] req_off_ticks,
   input  logic [7:0]  req_repeat_count,
   output logic        rsp_valid,
   output logic        rsp_pin_level
);

   localparam int FILL_W = $clog2(DEPTH + 1);

   logic              accept;
   logic              cmd_valid;
   cmd_type           cmd;
   logic [FILL_W-1:0] load_count;
   fifo_ctl_type      fifo_ctl;
   fifo_stat_type     fifo_stat;
   logic              tick_live;
   logic              expire;

   logic [DUR_W-1:0]  remaining_ff;
   logic [DUR_W-1:0]  remaining_in;
   logic              play_ff;
   logic              play_in;
   logic              pin_ff;
   logic              pin_in;
   logic              rsp_valid_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   tbsq_input_stage #(
      .DEPTH  (DEPTH),
      .FILL_W (FILL_W)
   ) u_input (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_mode          (req_mode),
      .req_segment_level (req_segment_level),
      .req_on_ticks      (req_on_ticks),
      .req_off_ticks     (req_off_ticks),
      .req_repeat_count  (req_repeat_count),
      .valid_ff          (cmd_valid),
      .cmd_ff            (cmd),
      .count_ff          (load_count)
   );

   // tick handling: count down, or pop when the countdown has expired
   assign tick_live = cmd_valid && cmd.tick && play_ff;
   assign expire    = tick_live && (remaining_ff == '0);

   always_comb begin
      fifo_ctl.load      = cmd_valid && cmd.load;
      fifo_ctl.push      = cmd_valid && cmd.append;
      fifo_ctl.pop       = expire && !fifo_stat.empty;
      fifo_ctl.alternate = cmd.alternate;
      fifo_ctl.level_a   = cmd.level_a;
      fifo_ctl.dur_a     = cmd.dur_a;
      fifo_ctl.dur_b     = cmd.dur_b;
   end

   tbsq_fifo #(
      .DEPTH  (DEPTH),
      .FILL_W (FILL_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (fifo_ctl),
      .load_count (load_count),
      .stat       (fifo_stat)
   );

   // countdown, playback enable and pin level
   always_comb begin
      remaining_in = remaining_ff;
      play_in      = play_ff;
      pin_in       = pin_ff;
      if (cmd_valid && cmd.load) begin
         remaining_in = '0;
         pin_in       = 1'b0;
         if (cmd.enable_play) begin
            play_in = 1'b1;
         end
      end else if (expire) begin
         if (fifo_stat.empty) begin
            pin_in = 1'b0;
         end else begin
            remaining_in = fifo_stat.head_dur;
            pin_in       = fifo_stat.head_level;
         end
      end else if (tick_live) begin
         remaining_in = remaining_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         play_ff      <= 1'b0;
         pin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         play_ff      <= play_in;
         pin_ff       <= pin_in;
         rsp_valid_ff <= cmd_valid;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = pin_ff;

endmodule

// ===== design/tbsq_checker.sv =====
// ----------------------------------------------------------------------------
// tbsq_checker
// port-level checks of the beep segment queue, bound to the top level
// ----------------------------------------------------------------------------
`include "timed_beep_segment_queue_core_defines.svh"

module tbsq_checker
   import tbsq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_pin_level
);

   logic take;
   logic quiet_cmd;

   assign take      = start && !busy;
   assign quiet_cmd = (req_mode == MODE_SINGLE) || (req_mode == MODE_SQUARE) ||
                      (req_mode == MODE_CLEAR);

   // every transaction gives exactly one result, through the input and result registers
   `TBSQ_ASSERT_AFTER2(a_result_follows, clock, reset, take, rsp_valid)
   `TBSQ_ASSERT_AFTER2(a_no_stray_result, clock, reset, !take, !rsp_valid)

   // single, square and clear leave the pin off until a tick pops a segment
   `TBSQ_ASSERT_AFTER2(a_restart_pin_off, clock, reset, take && quiet_cmd, !rsp_pin_level)

   // the core never stalls a command outside reset
   `TBSQ_ASSERT_IMPLIES(a_never_busy, clock, reset, !reset, !busy)

endmodule

bind timed_beep_segment_queue_core tbsq_checker u_tbsq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_pin_level (rsp_pin_level)
);
